// ----- rtl/hte_pkg.sv -----
`timescale 1ns / 1ps

package hte_pkg;

  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int BATCH_BYTES  = 4;
  localparam int BATCH_W      = BATCH_BYTES * 8;
  localparam int CNT_W        = 32;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_CODE_LEN);

  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  addr;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } tbl_write_t;

  typedef struct packed {
    logic              written;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } tbl_entry_t;

endpackage

// ----- rtl/hte_code_table.sv -----
`timescale 1ns / 1ps

module hte_code_table
  import hte_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tbl_write_t       wr,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] rd_addr,
  output tbl_entry_t       rd_data
);

  logic [CODE_W-1:0]      bits_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]       len_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written;

  // an entry never loaded reads with its valid bit clear; its bits and length are not reset
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bits_mem[wr.addr] <= wr.bits;
      len_mem[wr.addr]  <= (wr.len > LEN_LIMIT) ? LEN_LIMIT : wr.len;
    end
    if (rd_en) begin
      rd_data.bits    <= bits_mem[rd_addr];
      rd_data.len     <= len_mem[rd_addr];
      rd_data.written <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

endmodule

// ----- rtl/huffman_table_encoder_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit up)                                   Ends with
// s_axis    in   tuser: opcode; tdata: symbol, code_bits, code_len     word accepted
// m_axis    out  tuser: error; tdata: out_byte, bytes_written; tlast   word accepted
//
// An input word reaches the output through the registered table read and then through
// packing into the output buffer. Input words are taken every cycle while each produces
// at most one output word and the output accepts every word; an encode that fills more
// than one byte holds the input until the output buffer has drained, one byte per accepted word.
// Reset clears the pending bits, the byte count and every table valid bit.

module huffman_table_encoder_top
  import hte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol[7:0], code_bits[39:8], code_len[45:40]
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte[7:0], bytes_written[39:8]
  output logic [0:0]  m_axis_tuser,   // error
  output logic        m_axis_tlast
);

  tbl_write_t tbl_wr;
  tbl_entry_t tbl_rd;
  logic       in_fire;

  // stage 1: item with its table entry
  logic       s1_valid;
  logic [1:0] s1_op;

  // packer state
  logic [7:0] pend_byte;
  logic [2:0] pend_cnt;

  // output buffer
  logic               ob_valid;
  logic [BATCH_W-1:0] ob_bytes;
  logic [1:0]         ob_idx;
  logic [1:0]         ob_last_idx;
  logic               ob_err;
  logic [CNT_W-1:0]   byte_cnt;

  logic               ob_last;
  logic               ob_free;
  logic               out_fire;
  logic [CNT_W-1:0]   cnt_inc;

  logic [CODE_W-1:0]  code_mask;
  logic [39:0]        merged;
  logic [6:0]         total;
  logic [2:0]         nbytes;
  logic [7:0]         rem_byte;
  logic               enc_err;

  logic               s1_produce;
  logic               s1_adv;
  logic [BATCH_W-1:0] batch_bytes;
  logic [1:0]         batch_last_idx;
  logic               batch_err;
  logic [7:0]         pend_byte_next;
  logic [2:0]         pend_cnt_next;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign tbl_wr.en   = in_fire && (s_axis_tuser == OP_LOAD);
  assign tbl_wr.addr = s_axis_tdata[7:0];
  assign tbl_wr.bits = s_axis_tdata[39:8];
  assign tbl_wr.len  = s_axis_tdata[45:40];

  hte_code_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_en   (in_fire),
    .rd_addr (s_axis_tdata[7:0]),
    .rd_data (tbl_rd)
  );

  // bit packing
  assign code_mask = ~({CODE_W{1'b1}} << tbl_rd.len);
  assign merged    = ({8'b0, tbl_rd.bits & code_mask} << pend_cnt) | {32'b0, pend_byte};
  assign total     = {4'b0, pend_cnt} + {1'b0, tbl_rd.len};
  assign nbytes    = total[5:3];
  assign enc_err   = !tbl_rd.written || (tbl_rd.len == '0);

  always_comb begin
    case (nbytes)
      3'd0:    rem_byte = merged[7:0];
      3'd1:    rem_byte = merged[15:8];
      3'd2:    rem_byte = merged[23:16];
      3'd3:    rem_byte = merged[31:24];
      default: rem_byte = merged[39:32];
    endcase
  end

  always_comb begin
    s1_produce     = 1'b0;
    batch_bytes    = '0;
    batch_last_idx = '0;
    batch_err      = 1'b0;
    pend_byte_next = pend_byte;
    pend_cnt_next  = pend_cnt;
    unique case (s1_op)
      OP_ENCODE: begin
        if (enc_err) begin
          s1_produce = 1'b1;
          batch_err  = 1'b1;
        end else begin
          s1_produce     = (nbytes != 3'd0);
          batch_bytes    = merged[BATCH_W-1:0];
          batch_last_idx = 2'(nbytes - 3'd1);
          pend_byte_next = rem_byte;
          pend_cnt_next  = total[2:0];
        end
      end
      OP_FLUSH: begin
        s1_produce     = (pend_cnt != 3'd0);
        batch_bytes    = {24'b0, pend_byte};
        pend_byte_next = '0;
        pend_cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  assign ob_last       = (ob_idx == ob_last_idx);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign ob_free       = !ob_valid || (m_axis_tready && ob_last);
  assign s1_adv        = s1_valid && (!s1_produce || ob_free);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_byte <= '0;
      pend_cnt  <= '0;
    end else if (s1_adv) begin
      pend_byte <= pend_byte_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_idx   <= '0;
    end else if (s1_adv && s1_produce) begin
      ob_valid <= 1'b1;
      ob_idx   <= '0;
    end else if (out_fire) begin
      if (ob_last) begin
        ob_valid <= 1'b0;
      end
      ob_idx <= ob_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_produce) begin
      ob_bytes    <= batch_bytes;
      ob_last_idx <= batch_last_idx;
      ob_err      <= batch_err;
    end
  end

  assign cnt_inc = (byte_cnt == {CNT_W{1'b1}}) ? byte_cnt : byte_cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
    end else if (out_fire && !ob_err) begin
      byte_cnt <= cnt_inc;
    end
  end

  assign m_axis_tvalid       = ob_valid;
  assign m_axis_tdata[7:0]   = ob_bytes[ob_idx*8 +: 8];
  assign m_axis_tdata[39:8]  = ob_err ? byte_cnt : cnt_inc;
  assign m_axis_tuser        = ob_err;
  assign m_axis_tlast        = ob_last;

endmodule
